// ----- src/phkm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phkm_pkg
// Shared constants, slot layout and helpers of the point keyed hash map.
// ----------------------------------------------------------------------------
package phkm_pkg;

    localparam int NUM_BUCKETS = 1024;
    localparam int WAYS        = 4;
    localparam int SLOT_COUNT  = NUM_BUCKETS * WAYS;

    localparam int COORD_W = 32;
    localparam int VALUE_W = 32;
    localparam int FOLD_W  = 32;
    localparam int PROD_W  = 64;
    localparam int Y_SHIFT = 16;

    localparam logic [FOLD_W-1:0] HASH_MULT = 32'd2654435761;

    localparam int CFG_W     = 11;
    localparam int CFG_RESET = 1024;

    // bucket count register holds 1 .. NUM_BUCKETS
    localparam int CNT_W   = $clog2(NUM_BUCKETS + 1);
    localparam int BKT_AW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    // remainder unit: MOD_STEP dividend bits retired per cycle
    localparam int MOD_STEP  = 8;
    localparam int MOD_ITERS = PROD_W / MOD_STEP;
    localparam int ITER_W    = (MOD_ITERS > 1) ? $clog2(MOD_ITERS) : 1;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;
    localparam logic RES_OK    = 1'b0;
    localparam logic RES_ERR   = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               inf;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic busy;
        logic done;
    } phkm_mod_stat_t;

    // zero reads as one bucket, anything above the table size saturates
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0)
        begin
            wide = 32'd1;
        end
        else if (wide > 32'(NUM_BUCKETS))
        begin
            wide = 32'(NUM_BUCKETS);
        end
        return wide[CNT_W-1:0];
    endfunction

endpackage

// ----- src/point_keyed_hash_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_keyed_hash_map
// Point keyed map of signed values, multiplicative hash into WAYS-way buckets.
// ----------------------------------------------------------------------------
// Flow: after the input beat, a multiply state (ST_HASH), a start state (ST_DIVGO),
//   the remainder phase (eight steps of eight bits), a read and a check state
//   per way scanned (the scan stops on a hit, four ways at most), one update state.
// Occupancy: one item in flight; the next is taken once the last leaves the update state.
// Reset: a clearing pass writes every slot, with s_tready low;
//   bucket count resets to 1024.
// ----------------------------------------------------------------------------
module point_keyed_hash_map (
    input  logic                                clk,
    input  logic                                rst_n,
    // config beat: bucket_count
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [phkm_pkg::CFG_W-1:0]          cfg_data,
    // s_tdata: key_x[31:0], key_y[63:32], key_infinity[64], new_value[96:65]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [phkm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: operation[0]
    input  logic                                s_tuser,
    // m_tdata: status[0], found_value[32:1]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [phkm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import phkm_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_DIVGO = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [SLOT_AW-1:0] clr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               op_reg;
    logic [COORD_W-1:0] kx_reg;
    logic [COORD_W-1:0] ky_reg;
    logic               kinf_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [WAY_W-1:0]   way_reg;
    logic               hit_reg;
    logic               free_reg;
    logic [SLOT_AW-1:0] tgt_reg;
    logic [VALUE_W-1:0] hit_val_reg;

    logic               out_valid_reg;
    logic               out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic [FOLD_W-1:0]  fold;
    logic [CNT_W-1:0]   mod_rem;
    phkm_mod_stat_t     mod_stat;
    logic [SLOT_AW-1:0] base;
    logic [SLOT_AW-1:0] way_addr;
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_addr;
    slot_t              ram_wdata;
    slot_t              ram_rdata;
    logic               match;
    logic               out_free;
    logic               last_way;
    logic               in_beat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_way  = (way_reg == WAY_W'(WAYS - 1));

    assign fold = kx_reg ^ (ky_reg << Y_SHIFT) ^ {FOLD_W{kinf_reg}};

    phkm_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_DIVGO),
        .dividend  (prod_reg),
        .divisor   (count_reg),
        .remainder (mod_rem),
        .stat      (mod_stat)
    );

    assign base     = SLOT_AW'(32'(mod_rem[BKT_AW-1:0]) * 32'(WAYS));
    assign way_addr = base + SLOT_AW'(way_reg);

    // two points at infinity match whatever their coordinates
    assign match = ram_rdata.valid &&
                   ((ram_rdata.inf && kinf_reg) ||
                    (!ram_rdata.inf && !kinf_reg &&
                     ram_rdata.x == kx_reg && ram_rdata.y == ky_reg));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = way_addr;
        ram_wdata = '{valid: 1'b1, inf: kinf_reg, x: kx_reg, y: ky_reg, value: val_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
            end
            ST_DONE:
            begin
                ram_addr = tgt_reg;
                ram_we   = out_free && (op_reg == OP_INSERT) && (hit_reg || free_reg);
            end
            default:
            begin
                ram_addr = way_addr;
            end
        endcase
    end

    phkm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SLOT_AW'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:  state_next = ST_DIVGO;
            ST_DIVGO: state_next = ST_DIV;
            ST_DIV:
            begin
                if (mod_stat.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (match || last_way)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= clamp_count(CFG_W'(CFG_RESET));
            way_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= clamp_count(cfg_data);
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (in_beat)
            begin
                way_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            if (state_reg == ST_CHECK)
            begin
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                else if (!ram_rdata.valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (!last_way)
                begin
                    way_reg <= way_reg + 1'b1;
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg   <= s_tuser;
            kx_reg   <= s_tdata[31:0];
            ky_reg   <= s_tdata[63:32];
            kinf_reg <= s_tdata[64];
            val_reg  <= s_tdata[96:65];
        end
        if (state_reg == ST_HASH)
        begin
            prod_reg <= 64'(fold) * 64'(HASH_MULT);
        end
        if (state_reg == ST_CHECK)
        begin
            // first hit wins; otherwise remember the first free way
            if (match)
            begin
                tgt_reg     <= way_addr;
                hit_val_reg <= ram_rdata.value;
            end
            else if (!ram_rdata.valid && !free_reg)
            begin
                tgt_reg <= way_addr;
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                out_status_reg <= hit_reg ? RES_OK : RES_ERR;
                out_value_reg  <= hit_reg ? hit_val_reg : '0;
            end
            else
            begin
                out_status_reg <= (hit_reg || free_reg) ? RES_OK : RES_ERR;
                out_value_reg  <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_value_reg, out_status_reg});

    a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_DONE))
        else $error("slot RAM written outside clear pass or update");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result beat raised without an update cycle");

    a_mod_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (mod_stat.busy || mod_stat.done) |-> state_reg == ST_DIV)
        else $error("remainder unit active outside the divide phase");

    a_scan_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && $past(state_reg) == ST_DIV) |-> $past(mod_stat.done))
        else $error("bucket scan started before remainder was ready");

endmodule

// ----- src/phkm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phkm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module phkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/phkm_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phkm_mod
// Iterative remainder unit: 64-bit product modulo the bucket count,
// MOD_STEP restoring steps per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module phkm_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [phkm_pkg::PROD_W-1:0]   dividend,
    input  logic [phkm_pkg::CNT_W-1:0]    divisor,
    output logic [phkm_pkg::CNT_W-1:0]    remainder,
    output phkm_pkg::phkm_mod_stat_t      stat
);

    import phkm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [PROD_W-1:0] div_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;

    always_comb
    begin
        logic [CNT_W-1:0] r;
        logic [CNT_W:0]   t;
        r = rem_reg;
        for (int i = 0; i < MOD_STEP; i++)
        begin
            t = {r, div_reg[PROD_W-1-i]};
            if (t >= {1'b0, n_reg})
            begin
                t = t - {1'b0, n_reg};
            end
            r = t[CNT_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(MOD_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            n_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= div_reg << MOD_STEP;
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- bench/point_keyed_hash_map_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_keyed_hash_map_test
// Self-checking bench for the point keyed hash map. A short table of directed
// inserts and lookups (edge keys, infinity matching, full buckets, bucket
// count clamping) is followed by random traffic over a series of bucket
// counts. Results are checked against fixed table values or the map model.
// ----------------------------------------------------------------------------
module point_keyed_hash_map_test;

    import phkm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 150;
    localparam int POOL_SIZE    = 20;
    localparam int REPORT_MAX   = 10;
    localparam int MAX_WAIT     = 17;
    localparam int NUM_PHASES   = 8;
    localparam int DIR_ROWS     = 24;

    typedef enum logic [1:0] { ROW_ITEM, ROW_CFG } row_kind_e;
    typedef enum logic { CHK_MODEL, CHK_FIXED } row_check_e;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               inf;
        logic [VALUE_W-1:0] value;
    } map_req_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] value;
    } map_res_t;

    typedef struct packed {
        row_kind_e          kind;
        logic [CFG_W-1:0]   cfg;
        logic               op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               inf;
        logic [VALUE_W-1:0] value;
        row_check_e         check;
        logic               status;
        logic [VALUE_W-1:0] found;
    } dir_row_t;

    // kind, cfg, op, x, y, inf, value, check, status, found
    localparam dir_row_t DIRECTED_TAB [DIR_ROWS] = '{
        '{ROW_ITEM, 0, OP_LOOKUP, 'h0, 'h0, 0, 'h0, CHK_FIXED, RES_ERR, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'h0, 'h0, 0, 'h7fffffff, CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h0, 'h0, 0, 'h0, CHK_FIXED, RES_OK, 'h7fffffff},
        '{ROW_ITEM, 0, OP_INSERT, 'hffffffff, 'hffffffff, 0, 'h80000000,
          CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'hffffffff, 'hffffffff, 0, 'h1,
          CHK_FIXED, RES_OK, 'h80000000},
        '{ROW_ITEM, 0, OP_LOOKUP, 'hffffffff, 'hfffffffe, 0, 'h0, CHK_MODEL, 0, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'h1, 'h2, 1, 'h5, CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h1, 'h2, 1, 'h0, CHK_FIXED, RES_OK, 'h5},
        '{ROW_ITEM, 0, OP_LOOKUP, 'hffffffff, 'h0, 1, 'h0, CHK_MODEL, 0, 'h0},
        // single bucket: everything lands together
        '{ROW_CFG, 1, 0, 'h0, 'h0, 0, 'h0, CHK_MODEL, 0, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'h9, 'h9, 1, 'hffffffff, CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h0, 'hffffffff, 1, 'h0, CHK_FIXED, RES_OK, 'hffffffff},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h9, 'h9, 0, 'h0, CHK_FIXED, RES_ERR, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'h9, 'h9, 0, 'h12345678, CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'haaaaaaaa, 'h55555555, 0, 'h0, CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'h55555555, 'haaaaaaaa, 0, 'h1, CHK_FIXED, RES_ERR, 'h0},
        '{ROW_ITEM, 0, OP_INSERT, 'h9, 'h9, 0, 'h42, CHK_FIXED, RES_OK, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h9, 'h9, 0, 'h0, CHK_FIXED, RES_OK, 'h42},
        // zero reads as one bucket
        '{ROW_CFG, 0, 0, 'h0, 'h0, 0, 'h0, CHK_MODEL, 0, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'haaaaaaaa, 'h55555555, 0, 'h0, CHK_FIXED, RES_OK, 'h0},
        // oversize count saturates to the full table
        '{ROW_CFG, 'h7ff, 0, 'h0, 'h0, 0, 'h0, CHK_MODEL, 0, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h0, 'h0, 0, 'h0, CHK_FIXED, RES_OK, 'h7fffffff},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h9, 'h9, 0, 'h0, CHK_MODEL, 0, 'h0},
        '{ROW_ITEM, 0, OP_LOOKUP, 'h1, 'h2, 1, 'h0, CHK_FIXED, RES_OK, 'h5}
    };

    localparam logic [CFG_W-1:0] PHASE_BUCKETS [NUM_PHASES] = '{
        11'd1024, 11'd3, 11'd1, 11'd2047, 11'd0, 11'd37, 11'd1000, 11'd2
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // key_x, key_y, key_infinity, new_value
    logic                   s_tuser;    // operation
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // status, found_value

    // beat currently presented on the slave side
    map_req_t   on_bus;
    row_check_e on_bus_check;
    map_res_t   on_bus_res;

    // map model state
    bit                 map_used [SLOT_COUNT];
    logic [COORD_W-1:0] map_x    [SLOT_COUNT];
    logic [COORD_W-1:0] map_y    [SLOT_COUNT];
    bit                 map_inf  [SLOT_COUNT];
    logic [VALUE_W-1:0] map_val  [SLOT_COUNT];
    logic [CFG_W-1:0]   map_buckets_reg;

    map_res_t awaited_results [$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    int  item_count     = 0;
    int  hit_count      = 0;
    int  miss_count     = 0;
    int  full_count     = 0;
    int  cycle_count    = 0;
    bit  src_calm       = 1'b0;
    bit  snk_calm       = 1'b0;

    point_keyed_hash_map u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int live_buckets();
        int n;
        n = int'(map_buckets_reg);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > NUM_BUCKETS)
        begin
            n = NUM_BUCKETS;
        end
        return n;
    endfunction

    function automatic int bucket_of_point(map_req_t r);
        logic [FOLD_W-1:0] folded;
        logic [PROD_W-1:0] prod;
        folded = r.x ^ (r.y << Y_SHIFT) ^ {FOLD_W{r.inf}};
        prod   = PROD_W'(folded) * PROD_W'(HASH_MULT);
        return int'(prod % PROD_W'(live_buckets()));
    endfunction

    // apply one request to the model map and return the result beat it causes
    function automatic map_res_t map_access(map_req_t r);
        int       base;
        int       hit;
        int       free_slot;
        int       s;
        bit       same;
        map_res_t res;
        base      = bucket_of_point(r) * WAYS;
        hit       = -1;
        free_slot = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            s = base + w;
            if (map_used[s])
            begin
                // points at infinity match one another whatever the coordinates
                if (map_inf[s] || r.inf)
                begin
                    same = map_inf[s] && r.inf;
                end
                else
                begin
                    same = (map_x[s] == r.x) && (map_y[s] == r.y);
                end
                if (hit < 0 && same)
                begin
                    hit = s;
                end
            end
            else if (free_slot < 0)
            begin
                free_slot = s;
            end
        end
        res.status = RES_OK;
        res.value  = '0;
        if (r.op == OP_LOOKUP)
        begin
            if (hit >= 0)
            begin
                res.value = map_val[hit];
                hit_count++;
            end
            else
            begin
                res.status = RES_ERR;
                miss_count++;
            end
        end
        else if (hit >= 0)
        begin
            map_val[hit] = r.value;
        end
        else if (free_slot >= 0)
        begin
            map_used[free_slot] = 1'b1;
            map_x[free_slot]    = r.x;
            map_y[free_slot]    = r.y;
            map_inf[free_slot]  = r.inf;
            map_val[free_slot]  = r.value;
        end
        else
        begin
            res.status = RES_ERR;
            full_count++;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic send_item(input map_req_t r, input row_check_e chk,
                             input map_res_t fixed_res);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            src_calm = !src_calm;
        end
        gap = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid     <= 1'b1;
        s_tuser      <= r.op;
        s_tdata      <= IN_TDATA_W'({r.value, r.inf, r.y, r.x});
        on_bus       <= r;
        on_bus_check <= chk;
        on_bus_res   <= fixed_res;
        do @(posedge clk); while (!s_tready);
        item_count++;
    endtask

    // drop the slave side and hold until every awaited result has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
    endtask

    task automatic write_buckets(input logic [CFG_W-1:0] count);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mirror the register and predict each accepted beat, then check results
    always @(posedge clk)
    begin
        map_res_t want;
        map_res_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                map_buckets_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                want = map_access(on_bus);
                if (on_bus_check == CHK_FIXED)
                begin
                    want = on_bus_res;
                end
                awaited_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[0];
                got.value  = m_tdata[32:1];
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing awaited", '0, got.value);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        report_mismatch("status", VALUE_W'(want.status),
                                        VALUE_W'(got.status));
                    end
                    if (got.value !== want.value)
                    begin
                        report_mismatch("found_value", want.value, got.value);
                    end
                end
            end
        end
    end

    // result sink with random back-pressure
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                snk_calm = !snk_calm;
            end
            stall = snk_calm ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still awaited",
                 cycle_count, awaited_results.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        map_req_t r;
        map_res_t fixed_res;
        map_req_t pool [POOL_SIZE];
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_INSERT;
        on_bus       = '0;
        on_bus_check = CHK_MODEL;
        on_bus_res   = '0;
        map_buckets_reg = CFG_W'(CFG_RESET);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            map_used[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED_TAB[i].kind == ROW_CFG)
            begin
                write_buckets(DIRECTED_TAB[i].cfg);
            end
            else
            begin
                r.op             = DIRECTED_TAB[i].op;
                r.x              = DIRECTED_TAB[i].x;
                r.y              = DIRECTED_TAB[i].y;
                r.inf            = DIRECTED_TAB[i].inf;
                r.value          = DIRECTED_TAB[i].value;
                fixed_res.status = DIRECTED_TAB[i].status;
                fixed_res.value  = DIRECTED_TAB[i].found;
                send_item(r, DIRECTED_TAB[i].check, fixed_res);
            end
        end

        // mostly a small set of recurring keys so that updates, hits and full
        // buckets happen; the rest are fresh keys
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_buckets(PHASE_BUCKETS[p]);
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                pool[k].x   = $urandom;
                pool[k].y   = $urandom;
                pool[k].inf = ($urandom_range(0, 7) == 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r = pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                else
                begin
                    r.x   = $urandom;
                    r.y   = $urandom;
                    r.inf = 1'($urandom_range(0, 1));
                end
                r.op    = 1'($urandom_range(0, 1));
                r.value = $urandom;
                send_item(r, CHK_MODEL, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items over %0d bucket settings, checked %0d results",
                 item_count, NUM_PHASES + 3, result_count);
        $display("Lookups: %0d hits, %0d misses; inserts refused on full bucket: %0d",
                 hit_count, miss_count, full_count);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- point_keyed_hash_map.f -----
src/phkm_pkg.sv
src/phkm_ram.sv
src/phkm_mod.sv
src/point_keyed_hash_map.sv
bench/point_keyed_hash_map_test.sv
